[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned MagW = 64;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CMP   = 3'd4,
    OP_RED   = 3'd5,
    OP_RECIP = 3'd6,
    OP_RED2  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  localparam logic [1:0] OrdEq   = 2'd0;
  localparam logic [1:0] OrdGt   = 2'd1;
  localparam logic [1:0] OrdLt   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GCD_START,
    S_GCD_RUN,
    S_DIVN_START,
    S_DIVN_RUN,
    S_DIVD_START,
    S_DIVD_RUN,
    S_DONE
  } state_e;

  // request and reply between sequencer and divider
  typedef struct packed {
    logic            start;
    logic [MagW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MagW-1:0] quot;
    logic [MagW-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact add, subtract, multiply, divide, compare, reduce and reciprocal on
// two signed fractions, result reduced by a euclid gcd
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation and two fractions a and b; m_axis returns the
//   reduced result num/den with order and status, one transfer per input.
//   s_axis_tready is high only while the block is idle: one item is worked on
//   at a time. each item passes the cross products, one sum, then euclid
//   steps on the shared 64-bit restoring divider (one quotient bit per
//   cycle), then two exact divisions. the gcd step count (at most about 92
//   for 64-bit values) sets the worst case.
//   errors and zero numerators skip the divider.
//   the result is held in an output register until m_axis_tready; the next
//   input is accepted only after that transfer.
//   reset clears the sequencer and drops m_axis_tvalid; no clearing pass.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [127:0] s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_num[63:0], result_den[126:64], order[128:127], status[130:129],
  // zero fill[135:131]
  output logic [135:0] m_axis_tdata
);

  localparam int unsigned W  = rau_pkg::MagW;
  localparam int unsigned OW = OPERAND_WIDTH;

  // operand magnitudes and signs, the sign taken from the top bit of the used width
  logic [OW-1:0] raw [4];
  logic [OW-1:0] mag [4];
  logic [3:0]    sgn;

  assign raw[0] = s_axis_tdata[OW-1:0];
  assign raw[1] = s_axis_tdata[32+OW-1:32];
  assign raw[2] = s_axis_tdata[64+OW-1:64];
  assign raw[3] = s_axis_tdata[96+OW-1:96];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sgn[i] = raw[i][OW-1];
      mag[i] = sgn[i] ? (~raw[i] + 1'b1) : raw[i];
    end
  end

  rau_pkg::state_e state_q, state_d;
  rau_pkg::op_e    op_q, op_d;
  logic [OW-1:0]   om_q [4];
  logic [OW-1:0]   om_d [4];
  logic [3:0]      os_q, os_d;
  // products: p0 = an*bd or n, p1 = ad*bn or d
  logic [W-1:0]    p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic            s0_q, s0_d, s1_q, s1_d;
  logic [W-1:0]    nm_q, nm_d, dm_q, dm_d;
  logic            neg_q, neg_d;
  logic [W-1:0]    gb_q, gb_d;
  logic [W-1:0]    rnum_q, rnum_d;
  logic [W-2:0]    rden_q, rden_d;
  logic [1:0]      ord_q, ord_d;
  rau_pkg::status_e st_q, st_d;
  logic            ovalid_q, ovalid_d;

  // shared multiplier operands (one 32x32 product per cycle)
  logic [OW-1:0]   mul_x, mul_y;
  logic [W-1:0]    mul_p;
  assign mul_p = W'(mul_x) * W'(mul_y);

  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;

  rau_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  logic accept;
  assign s_axis_tready = (state_q == rau_pkg::S_IDLE) && !ovalid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [W:0]   sum_w;
  logic         sub_eff;
  logic         bin_op;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    om_d     = om_q;
    os_d     = os_q;
    p0_d     = p0_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    s0_d     = s0_q;
    s1_d     = s1_q;
    nm_d     = nm_q;
    dm_d     = dm_q;
    neg_d    = neg_q;
    gb_d     = gb_q;
    rnum_d   = rnum_q;
    rden_d   = rden_q;
    ord_d    = ord_q;
    st_d     = st_q;
    ovalid_d = ovalid_q;
    mul_x    = om_q[0];
    mul_y    = om_q[3];
    dreq     = '0;
    sum_w    = '0;
    sub_eff  = 1'b0;
    bin_op   = (op_q == rau_pkg::OP_ADD) || (op_q == rau_pkg::OP_SUB) ||
               (op_q == rau_pkg::OP_MUL) || (op_q == rau_pkg::OP_DIV) ||
               (op_q == rau_pkg::OP_CMP);

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      rau_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = rau_pkg::op_e'(s_axis_tuser);
          om_d  = mag;
          os_d  = sgn;
          state_d = rau_pkg::S_MUL0;
        end
      end
      rau_pkg::S_MUL0: begin
        // status checks and first product
        rnum_d = '0;
        rden_d = '0;
        ord_d  = rau_pkg::OrdEq;
        st_d   = rau_pkg::ST_OK;
        if (om_q[1] == '0 || (bin_op && om_q[3] == '0)) begin
          st_d    = rau_pkg::ST_ZERODEN;
          state_d = rau_pkg::S_DONE;
        end else if ((op_q == rau_pkg::OP_DIV && om_q[2] == '0) ||
                     (op_q == rau_pkg::OP_RECIP && om_q[0] == '0)) begin
          st_d    = rau_pkg::ST_DIVZERO;
          state_d = rau_pkg::S_DONE;
        end else begin
          // an * bd for add, sub, cmp, div; an * bn for mul
          mul_x = om_q[0];
          mul_y = (op_q == rau_pkg::OP_MUL) ? om_q[2] : om_q[3];
          p0_d  = mul_p;
          s0_d  = (mul_p != '0) && (os_q[0] != ((op_q == rau_pkg::OP_MUL) ?
                                                os_q[2] : os_q[3]));
          state_d = rau_pkg::S_MUL1;
        end
      end
      rau_pkg::S_MUL1: begin
        // ad * bn for add, sub, cmp, div; ad * bd for mul
        mul_x = om_q[1];
        mul_y = (op_q == rau_pkg::OP_MUL) ? om_q[3] : om_q[2];
        p1_d  = mul_p;
        s1_d  = (mul_p != '0) && (os_q[1] != ((op_q == rau_pkg::OP_MUL) ?
                                              os_q[3] : os_q[2]));
        state_d = rau_pkg::S_MUL2;
      end
      rau_pkg::S_MUL2: begin
        // ad * bd as common denominator
        mul_x = om_q[1];
        mul_y = om_q[3];
        p2_d  = mul_p;
        state_d = rau_pkg::S_SUM;
      end
      rau_pkg::S_SUM: begin
        case (op_q)
          rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_CMP: begin
            sub_eff = (op_q != rau_pkg::OP_ADD);
            // s1 sign after optional negation; the sign of ad*bd folds in too
            if (s0_q == (s1_q ^ (sub_eff && p1_q != '0))) begin
              sum_w = {1'b0, p0_q} + {1'b0, p1_q};
              nm_d  = sum_w[W-1:0];
              neg_d = s0_q ^ os_q[1] ^ os_q[3];
            end else if (p0_q >= p1_q) begin
              nm_d  = p0_q - p1_q;
              neg_d = s0_q ^ os_q[1] ^ os_q[3];
            end else begin
              nm_d  = p1_q - p0_q;
              neg_d = ~s0_q ^ os_q[1] ^ os_q[3];
            end
            dm_d = p2_q;
          end
          rau_pkg::OP_MUL: begin
            nm_d  = p0_q;
            neg_d = s0_q ^ s1_q;
            dm_d  = p1_q;
          end
          rau_pkg::OP_DIV: begin
            nm_d  = p0_q;
            neg_d = s0_q ^ s1_q;
            dm_d  = p1_q;
          end
          rau_pkg::OP_RECIP: begin
            nm_d  = W'(om_q[1]);
            dm_d  = W'(om_q[0]);
            neg_d = os_q[1] ^ os_q[0];
          end
          default: begin
            nm_d  = W'(om_q[0]);
            dm_d  = W'(om_q[1]);
            neg_d = os_q[0] ^ os_q[1];
          end
        endcase
        state_d = rau_pkg::S_GCD_START;
      end
      rau_pkg::S_GCD_START: begin
        if (nm_q == '0) begin
          rnum_d  = '0;
          rden_d  = (W-1)'(1);
          ord_d   = rau_pkg::OrdEq;
          state_d = rau_pkg::S_DONE;
        end else begin
          gb_d    = dm_q;
          state_d = rau_pkg::S_GCD_RUN;
          dreq.start    = 1'b1;
          dreq.dividend = nm_q;
          dreq.divisor  = dm_q;
        end
      end
      rau_pkg::S_GCD_RUN: begin
        if (drsp.done) begin
          if (drsp.rem == '0) begin
            // gcd is gb
            state_d = rau_pkg::S_DIVN_START;
          end else begin
            gb_d = drsp.rem;
            dreq.start    = 1'b1;
            dreq.dividend = gb_q;
            dreq.divisor  = drsp.rem;
          end
        end
      end
      rau_pkg::S_DIVN_START: begin
        dreq.start    = 1'b1;
        dreq.dividend = nm_q;
        dreq.divisor  = gb_q;
        state_d       = rau_pkg::S_DIVN_RUN;
      end
      rau_pkg::S_DIVN_RUN: begin
        if (drsp.done) begin
          nm_d          = drsp.quot;
          dreq.start    = 1'b1;
          dreq.dividend = dm_q;
          dreq.divisor  = gb_q;
          state_d       = rau_pkg::S_DIVD_RUN;
        end
      end
      rau_pkg::S_DIVD_START: begin
        state_d = rau_pkg::S_DIVD_RUN;
      end
      rau_pkg::S_DIVD_RUN: begin
        if (drsp.done) begin
          rden_d = drsp.quot[W-2:0];
          if (neg_q) begin
            rnum_d = ~nm_q + 1'b1;
          end else if (nm_q[W-1]) begin
            rnum_d = {1'b0, {(W-1){1'b1}}};
          end else begin
            rnum_d = nm_q;
          end
          if (op_q == rau_pkg::OP_CMP) begin
            ord_d = neg_q ? rau_pkg::OrdLt : rau_pkg::OrdGt;
          end
          state_d = rau_pkg::S_DONE;
        end
      end
      rau_pkg::S_DONE: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          state_d  = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rau_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rau_pkg::S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    om_q   <= om_d;
    os_q   <= os_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    nm_q   <= nm_d;
    dm_q   <= dm_d;
    neg_q  <= neg_d;
    gb_q   <= gb_d;
    rnum_q <= rnum_d;
    rden_q <= rden_d;
    ord_q  <= ord_d;
    st_q   <= st_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, st_q, ord_q, rden_q, rnum_q};

`ifndef SYNTHESIS
  // no new item while a result waits
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");

  // an error result carries a zero fraction
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st_q != rau_pkg::ST_OK) |-> (rden_q == '0 && rnum_q == '0))
    else $error("error result not cleared");

  // a good result has a nonzero denominator
  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st_q == rau_pkg::ST_OK) |-> (rden_q != '0))
    else $error("zero denominator on good result");

  // the divider is only restarted when idle or finishing
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> (!drsp.busy))
    else $error("divider restarted while busy");
`endif

endmodule

[rtl/core/rau_divider.sv]
// ----------------------------------------------------------------------------
// rau_divider
// restoring divider, one quotient bit per cycle, shared for gcd and reduction
// ----------------------------------------------------------------------------
module rau_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = rau_pkg::MagW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quot_q, quot_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [W:0]      trial;
  logic [W:0]      diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
      end else begin
        rem_d = trial[W-1:0];
      end
      quot_d = {quot_q[W-2:0], ~diff[W]};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule
